// File: rtl/truncated_obstacle_distance_map_assert.svh
// assertion macros used by the checker file of the distance map block
`ifndef TRUNCATED_OBSTACLE_DISTANCE_MAP_ASSERT_SVH
`define TRUNCATED_OBSTACLE_DISTANCE_MAP_ASSERT_SVH

// clocked assertion, suspended while reset is high
`define TODM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("todm assertion failed");

// clocked assertion that also holds across reset
`define TODM_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("todm reset assertion failed");

`endif

// File: rtl/todm_pkg.sv
// shared types and constants of the obstacle distance map
`default_nettype none

package todm_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_RADIUS_DEF = 8;

  localparam int CELL_W   = 8;
  localparam int DIST_W   = 16;
  localparam int WIDTH_W  = 11;
  localparam int HEIGHT_W = 16;
  localparam int RADIUS_W = 4;
  localparam int CSIZE_W  = 16;
  localparam int APB_AW   = 5;
  localparam int APB_DW   = 32;

  localparam logic signed [CELL_W-1:0] OCC_CODE = 8'sd100;

  localparam logic [WIDTH_W-1:0]  MAP_WIDTH_RST     = 11'd1024;
  localparam logic [HEIGHT_W-1:0] MAP_HEIGHT_RST    = 16'd1024;
  localparam logic [RADIUS_W-1:0] SEARCH_RADIUS_RST = 4'd8;
  localparam logic [CSIZE_W-1:0]  CELL_SIZE_RST     = 16'd3277;
  localparam logic [DIST_W-1:0]   MAX_DISTANCE_RST  = 16'd2048;

  typedef enum logic [2:0] {
    CFG_MAP_WIDTH     = 3'd0,
    CFG_MAP_HEIGHT    = 3'd1,
    CFG_SEARCH_RADIUS = 3'd2,
    CFG_CELL_SIZE     = 3'd3,
    CFG_MAX_DISTANCE  = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic shift;
    logic advance;
  } cell_ctl_t;

endpackage

`default_nettype wire

// File: rtl/todm_if.sv
// stream interfaces for grid cells and distance results
`default_nettype none

interface todm_in_if;
  import todm_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [CELL_W-1:0] cell_value;
  logic                     flush;
  modport source (output valid, cell_value, flush, input ready);
  modport sink (input valid, cell_value, flush, output ready);
endinterface

interface todm_out_if;
  import todm_pkg::*;
  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] distance;
  logic              last;
  modport source (output valid, distance, last, input ready);
  modport sink (input valid, distance, last, output ready);
endinterface

`default_nettype wire

// File: rtl/todm_line_buf.sv
// one-bit line buffer that delays a window row by one map row
`default_nettype none

module todm_line_buf #(
  parameter int DEPTH = todm_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     shift,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  input  wire logic                     din,
  output logic                          dout
);
  logic mem [DEPTH];

  // read prefetches the bit needed at the next shift
  always_ff @(posedge clk) begin
    if (shift) begin
      mem[wr_addr] <= din;
      dout <= (rd_addr == wr_addr) ? din : mem[rd_addr];
    end
  end
endmodule

`default_nettype wire

// File: rtl/todm_row_cell.sv
// one window row: shift register and nearest-column search
`default_nettype none

module todm_row_cell #(
  parameter int MAX_RADIUS = todm_pkg::MAX_RADIUS_DEF
) (
  input  wire logic                                               clk,
  input  wire logic                                               rst,
  input  wire todm_pkg::cell_ctl_t                                ctl,
  input  wire logic                                               bit_in,
  input  wire logic [2*MAX_RADIUS:0]                              col_mask,
  input  wire logic                                               row_en,
  input  wire logic [$clog2(MAX_RADIUS+1)-1:0]                    radius,
  input  wire logic [$clog2(2*MAX_RADIUS*MAX_RADIUS+1)-1:0]       dr_sq,
  output logic                                                    found,
  output logic [$clog2(2*MAX_RADIUS*MAX_RADIUS+1)-1:0]            d2
);
  import todm_pkg::*;

  localparam int N     = 2*MAX_RADIUS+1;
  localparam int IDX_W = $clog2(N);
  localparam int RAD_W = $clog2(MAX_RADIUS+1);
  localparam int D2_W  = $clog2(2*MAX_RADIUS*MAX_RADIUS+1);

  logic [N-1:0]          win;
  logic [N-1:0]          masked;
  logic [MAX_RADIUS:0]   hit;
  logic [RAD_W-1:0]      best_t;
  logic                  found_c;
  logic [D2_W-1:0]       d2_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (ctl.shift) begin
      win <= {win[N-2:0], bit_in};
    end
  end

  // hit[t]: an obstacle lies t columns left or right of the center
  always_comb begin
    masked = win & col_mask & {N{row_en}};
    for (int t = 0; t <= MAX_RADIUS; t++) begin
      if (32'(radius) >= t) begin
        hit[t] = masked[IDX_W'(32'(radius) - t)] | masked[IDX_W'(32'(radius) + t)];
      end else begin
        hit[t] = 1'b0;
      end
    end
    best_t = '0;
    for (int t = MAX_RADIUS; t >= 0; t--) begin
      if (hit[t]) begin
        best_t = RAD_W'(t);
      end
    end
    found_c = |hit;
    d2_c = dr_sq + D2_W'(best_t) * D2_W'(best_t);
  end

  always_ff @(posedge clk) begin
    if (ctl.advance) begin
      found <= found_c;
      d2 <= d2_c;
    end
  end
endmodule

`default_nettype wire

// File: rtl/todm_isqrt.sv
// pipelined integer square root, one root bit per stage
`default_nettype none

module todm_isqrt #(
  parameter int IN_W = 40
) (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [IN_W-1:0]   din,
  output logic [IN_W/2-1:0]      root
);
  localparam int RW    = IN_W/2;
  localparam int REM_W = RW+3;

  logic [IN_W-1:0]  v_q    [RW];
  logic [REM_W-1:0] rem_q  [RW];
  logic [RW-1:0]    root_q [RW];

  for (genvar s = 0; s < RW; s++) begin : g_stage
    logic [IN_W-1:0]  v_in;
    logic [REM_W-1:0] rem_in;
    logic [RW-1:0]    root_in;
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             ge;

    if (s == 0) begin : g_first
      assign v_in    = din;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign v_in    = v_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
    end

    assign rem_sh = {rem_in[REM_W-3:0], v_in[IN_W-1 -: 2]};
    assign trial  = REM_W'({root_in, 2'b01});
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        v_q[s]    <= {v_in[IN_W-3:0], 2'b00};
        rem_q[s]  <= ge ? rem_sh - trial : rem_sh;
        root_q[s] <= {root_in[RW-2:0], ge};
      end
    end
  end

  assign root = root_q[RW-1];
endmodule

`default_nettype wire

// File: rtl/truncated_obstacle_distance_map.sv
// top level of the truncated obstacle distance map
// throughput: one grid cell per cycle and one result per cycle once the window is full,
//   while the output register is not stalled by the consumer
// the result for cell q appears after the transaction that carries cell q + radius*width + radius
// on its way it passes the chain of row cells, the min tree, two multiplies and the root pipeline
// reset: synchronous; clears counters, window bits and config to defaults;
//   line buffers need no clearing pass, their stale bits lie outside the map
`default_nettype none

module truncated_obstacle_distance_map #(
  parameter int MAX_WIDTH  = todm_pkg::MAX_WIDTH_DEF,
  parameter int MAX_RADIUS = todm_pkg::MAX_RADIUS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [todm_pkg::APB_AW-1:0] paddr,
  input  wire logic [todm_pkg::APB_DW-1:0] pwdata,
  output logic      [todm_pkg::APB_DW-1:0] prdata,
  output logic                             pready,
  todm_in_if.sink                          cells,
  todm_out_if.source                       results
);
  import todm_pkg::*;

  localparam int N        = 2*MAX_RADIUS+1;
  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int WEFF_W   = $clog2(MAX_WIDTH+1);
  localparam int RAD_W    = $clog2(MAX_RADIUS+1);
  localparam int D2_W     = $clog2(2*MAX_RADIUS*MAX_RADIUS+1);
  localparam int LAG_MAX  = MAX_RADIUS*MAX_WIDTH + MAX_RADIUS;
  localparam int DIFF_W   = $clog2(LAG_MAX+1);
  localparam int P1_W     = D2_W + CSIZE_W;
  localparam int V_W      = P1_W + CSIZE_W;
  localparam int SQ_W     = V_W + (V_W % 2);
  localparam int ROOT_W   = SQ_W/2;
  localparam int NST      = 5 + ROOT_W;
  localparam int G        = (N+3)/4;

  // configuration registers
  logic [WIDTH_W-1:0]  map_width;
  logic [HEIGHT_W-1:0] map_height;
  logic [RADIUS_W-1:0] search_radius;
  logic [CSIZE_W-1:0]  cell_size;
  logic [DIST_W-1:0]   max_distance;
  logic                wr_en;
  logic [2:0]          reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[APB_AW-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      map_width     <= MAP_WIDTH_RST;
      map_height    <= MAP_HEIGHT_RST;
      search_radius <= SEARCH_RADIUS_RST;
      cell_size     <= CELL_SIZE_RST;
      max_distance  <= MAX_DISTANCE_RST;
    end else if (wr_en) begin
      case (reg_idx)
        CFG_MAP_WIDTH:     map_width     <= pwdata[WIDTH_W-1:0];
        CFG_MAP_HEIGHT:    map_height    <= pwdata[HEIGHT_W-1:0];
        CFG_SEARCH_RADIUS: search_radius <= pwdata[RADIUS_W-1:0];
        CFG_CELL_SIZE:     cell_size     <= pwdata[CSIZE_W-1:0];
        CFG_MAX_DISTANCE:  max_distance  <= pwdata[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      CFG_MAP_WIDTH:     prdata = APB_DW'(map_width);
      CFG_MAP_HEIGHT:    prdata = APB_DW'(map_height);
      CFG_SEARCH_RADIUS: prdata = APB_DW'(search_radius);
      CFG_CELL_SIZE:     prdata = APB_DW'(cell_size);
      CFG_MAX_DISTANCE:  prdata = APB_DW'(max_distance);
      default:           prdata = '0;
    endcase
  end

  // effective map geometry, out-of-range settings clamped
  logic [WEFF_W-1:0]   w_eff;
  logic [HEIGHT_W-1:0] h_eff;
  logic [RAD_W-1:0]    r_eff;
  logic [DIFF_W-1:0]   lag;

  always_comb begin
    if (map_width == '0) begin
      w_eff = WEFF_W'(1);
    end else if (32'(map_width) > MAX_WIDTH) begin
      w_eff = WEFF_W'(MAX_WIDTH);
    end else begin
      w_eff = WEFF_W'(map_width);
    end
    h_eff = (map_height == '0) ? HEIGHT_W'(1) : map_height;
    r_eff = (32'(search_radius) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : RAD_W'(search_radius);
  end

  // cells between the newest transaction and the cell being reported
  assign lag = DIFF_W'(r_eff) * DIFF_W'(w_eff) + DIFF_W'(r_eff);

  // handshake: the whole pipeline moves when the output register is free
  logic accept, advance, occ;
  assign advance     = !results.valid || results.ready;
  assign cells.ready = advance;
  assign accept      = cells.valid && advance;
  assign occ         = (cells.cell_value == OCC_CODE) && !cells.flush;

  // output position tracking and result scheduling
  logic [HEIGHT_W-1:0] out_row;
  logic [COL_W-1:0]    out_col;
  logic [DIFF_W-1:0]   diff;
  logic [COL_W-1:0]    ptr;
  logic [COL_W-1:0]    ptr_next;
  logic                emit, at_last, col_wrap;

  assign emit     = (diff >= lag);
  assign at_last  = (out_row > h_eff - HEIGHT_W'(1)) ||
                    ((out_row == h_eff - HEIGHT_W'(1)) &&
                     (WEFF_W'(out_col) >= w_eff - WEFF_W'(1)));
  assign col_wrap = (WEFF_W'(out_col) + WEFF_W'(1) >= w_eff);
  // line buffer pointer restarts with every map so a new width lines up
  assign ptr_next = ((emit && at_last) || (WEFF_W'(ptr) + WEFF_W'(1) >= w_eff)) ?
                    '0 : ptr + COL_W'(1);

  logic                s0_valid;
  logic [HEIGHT_W-1:0] s0_row;
  logic [COL_W-1:0]    s0_col;
  logic                s0_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_row  <= '0;
      out_col  <= '0;
      diff     <= '0;
      ptr      <= '0;
      s0_valid <= 1'b0;
    end else begin
      if (accept) begin
        ptr <= ptr_next;
        if (emit) begin
          if (at_last) begin
            // frame done, next transaction starts a new map
            out_row <= '0;
            out_col <= '0;
            diff    <= '0;
          end else if (col_wrap) begin
            out_col <= '0;
            out_row <= out_row + HEIGHT_W'(1);
          end else begin
            out_col <= out_col + COL_W'(1);
          end
        end else begin
          diff <= diff + DIFF_W'(1);
        end
      end
      if (advance) begin
        s0_valid <= accept && emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s0_row  <= out_row;
      s0_col  <= out_col;
      s0_last <= at_last;
    end
  end

  // window clipping at the map edges
  logic [N-1:0]      col_mask;
  logic [N-1:0]      row_en;
  logic [D2_W-1:0]   dr_sq [N];
  logic [COL_W:0]    col_span;
  logic [HEIGHT_W:0] row_span;

  assign col_span = {1'b0, s0_col} + (COL_W+1)'(r_eff);
  assign row_span = {1'b0, s0_row} + (HEIGHT_W+1)'(r_eff);

  for (genvar k = 0; k < N; k++) begin : g_mask
    logic [RAD_W:0] dr_abs;
    // column k of a row holds the cell radius-k columns off center
    assign col_mask[k] = (2*32'(r_eff) >= k) && (32'(col_span) >= k) &&
                         (32'(col_span) - k < 32'(w_eff));
    // row k holds the cells radius-k rows off center
    assign row_en[k]   = (2*32'(r_eff) >= k) && (32'(row_span) >= k) &&
                         (32'(row_span) - k < 32'(h_eff));
    assign dr_abs      = (32'(r_eff) >= k) ? (RAD_W+1)'(32'(r_eff) - k)
                                           : (RAD_W+1)'(k - 32'(r_eff));
    assign dr_sq[k]    = D2_W'(dr_abs) * D2_W'(dr_abs);
  end

  // chain of row cells linked by line buffers
  cell_ctl_t         ctl;
  logic [N-1:0]      row_in;
  logic [N-2:0]      lb_out;
  logic [N-1:0]      c_found;
  logic [D2_W-1:0]   c_d2 [N];

  assign ctl.shift   = accept;
  assign ctl.advance = advance;
  assign row_in[0]   = occ;

  for (genvar k = 0; k < N; k++) begin : g_row
    if (k > 0) begin : g_link
      assign row_in[k] = lb_out[k-1];
    end
    if (k < N-1) begin : g_lb
      todm_line_buf #(
        .DEPTH (MAX_WIDTH)
      ) u_lb (
        .clk     (clk),
        .shift   (accept),
        .wr_addr (ptr),
        .rd_addr (ptr_next),
        .din     (row_in[k]),
        .dout    (lb_out[k])
      );
    end
    todm_row_cell #(
      .MAX_RADIUS (MAX_RADIUS)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .bit_in   (row_in[k]),
      .col_mask (col_mask),
      .row_en   (row_en[k]),
      .radius   (r_eff),
      .dr_sq    (dr_sq[k]),
      .found    (c_found[k]),
      .d2       (c_d2[k])
    );
  end

  // two-level min tree over the row results
  logic            g_f_c [G];
  logic [D2_W-1:0] g_d_c [G];
  logic            s2_f  [G];
  logic [D2_W-1:0] s2_d  [G];
  logic            s3_f_c, s3_f;
  logic [D2_W-1:0] s3_d_c, s3_d;

  always_comb begin
    for (int g = 0; g < G; g++) begin
      g_f_c[g] = 1'b0;
      g_d_c[g] = '0;
      for (int i = 0; i < 4; i++) begin
        if (4*g + i < N) begin
          if (c_found[4*g+i] && (!g_f_c[g] || c_d2[4*g+i] < g_d_c[g])) begin
            g_f_c[g] = 1'b1;
            g_d_c[g] = c_d2[4*g+i];
          end
        end
      end
    end
    s3_f_c = 1'b0;
    s3_d_c = '0;
    for (int g = 0; g < G; g++) begin
      if (s2_f[g] && (!s3_f_c || s2_d[g] < s3_d_c)) begin
        s3_f_c = 1'b1;
        s3_d_c = s2_d[g];
      end
    end
  end

  // scale: d2 * cell_size^2 in two multiplies
  logic [P1_W-1:0]   p1;
  logic [V_W-1:0]    p2;
  logic [ROOT_W-1:0] root;

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int g = 0; g < G; g++) begin
        s2_f[g] <= g_f_c[g];
        s2_d[g] <= g_d_c[g];
      end
      s3_f <= s3_f_c;
      s3_d <= s3_d_c;
      p1   <= P1_W'(s3_d) * P1_W'(cell_size);
      p2   <= V_W'(p1) * V_W'(cell_size);
    end
  end

  todm_isqrt #(
    .IN_W (SQ_W)
  ) u_isqrt (
    .clk  (clk),
    .en   (advance),
    .din  (SQ_W'(p2)),
    .root (root)
  );

  // valid, last and found travel beside the data
  logic vpipe [NST];
  logic lpipe [NST];
  logic fdel  [NST-3];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NST; i++) begin
        vpipe[i] <= 1'b0;
      end
    end else if (advance) begin
      vpipe[0] <= s0_valid;
      for (int i = 1; i < NST; i++) begin
        vpipe[i] <= vpipe[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      lpipe[0] <= s0_last;
      for (int i = 1; i < NST; i++) begin
        lpipe[i] <= lpipe[i-1];
      end
      fdel[0] <= s3_f;
      for (int i = 1; i < NST-3; i++) begin
        fdel[i] <= fdel[i-1];
      end
    end
  end

  // Q4.12 distance, saturated at max_distance
  logic [ROOT_W-5:0] dist_full;
  logic [DIST_W-1:0] dist_sel;

  assign dist_full = root[ROOT_W-1:4];
  assign dist_sel  = (fdel[NST-4] && (32'(dist_full) < 32'(max_distance)))
                     ? DIST_W'(dist_full) : max_distance;

  // output register parts the stream from the consumer
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (advance) begin
      results.valid <= vpipe[NST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      results.distance <= dist_sel;
      results.last     <= lpipe[NST-1];
    end
  end
endmodule

`default_nettype wire

// File: rtl/todm_checker.sv
// port-level checker of the distance map, bound to the top level
`default_nettype none
`include "truncated_obstacle_distance_map_assert.svh"

module todm_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] out_distance,
  input wire logic        out_last
);
  `TODM_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid)
  `TODM_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(out_distance) && $stable(out_last))
  `TODM_ASSERT(a_stall_only_on_full, !in_ready |-> out_valid && !out_ready)
  `TODM_ASSERT_RST(a_reset_clears, rst |=> !out_valid)
endmodule

bind truncated_obstacle_distance_map todm_checker u_todm_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (cells.ready),
  .out_valid    (results.valid),
  .out_ready    (results.ready),
  .out_distance (results.distance),
  .out_last     (results.last)
);

`default_nettype wire
